// ----- src/kfsl_pkg.sv -----
// Shared constants, codes and handshake structs of the keyframe segment lookup.
package kfsl_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int TIME_W    = 32;
  localparam int WIDE_W    = TIME_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int STEP_W    = $clog2(TIME_W) + 1;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  // Request to the shared restoring divider.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [WIDE_W-1:0] init_rem;
    logic [TIME_W-1:0] dividend;
    logic [WIDE_W-1:0] divisor;
  } div_req_t;

  // Status and results of the shared divider.
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [WIDE_W-1:0]    rem;
    logic [FRAC_BITS-1:0] quot;
  } div_rsp_t;

endpackage

// ----- src/kfsl_if.sv -----
// Handshake channel interfaces of the keyframe segment lookup.
interface kfsl_in_if;
  logic                                valid;
  logic                                ready;
  logic [kfsl_pkg::OP_W-1:0]           operation;
  logic [kfsl_pkg::TIME_W-1:0]         key_time;
  logic signed [kfsl_pkg::TIME_W-1:0]  query_time;
  modport source (output valid, operation, key_time, query_time, input ready);
  modport sink (input valid, operation, key_time, query_time, output ready);
endinterface

interface kfsl_out_if;
  logic                           valid;
  logic                           ready;
  logic [kfsl_pkg::STAT_W-1:0]    status;
  logic [kfsl_pkg::IDX_W-1:0]     first_index;
  logic [kfsl_pkg::IDX_W-1:0]     second_index;
  logic [kfsl_pkg::FRAC_W-1:0]    blend_fraction;
  modport source (output valid, status, first_index, second_index, blend_fraction,
                  input ready);
  modport sink (input valid, status, first_index, second_index, blend_fraction,
                output ready);
endinterface

interface kfsl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [kfsl_pkg::TIME_W-1:0]  animation_length;
  modport source (output valid, animation_length, input ready);
  modport sink (input valid, animation_length, output ready);
endinterface

// ----- src/kfsl_div.sv -----
// Shared restoring divider, one quotient bit per cycle, for modulo and fraction.
module kfsl_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kfsl_pkg::div_req_t  req_i,
  output kfsl_pkg::div_rsp_t  rsp_o
);

  logic [kfsl_pkg::WIDE_W-1:0]    rem_q, rem_d;
  logic [kfsl_pkg::TIME_W-1:0]    dvd_q, dvd_d;
  logic [kfsl_pkg::WIDE_W-1:0]    dvs_q, dvs_d;
  logic [kfsl_pkg::FRAC_BITS-1:0] quot_q, quot_d;
  logic [kfsl_pkg::STEP_W-1:0]    cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;

  logic [kfsl_pkg::WIDE_W:0]      shifted;
  logic                           ge;

  // One trial subtraction of the divisor from the remainder with the next bit shifted in.
  assign shifted = {rem_q, dvd_q[kfsl_pkg::TIME_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.init_rem;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quot_d = '0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = kfsl_pkg::WIDE_W'(shifted - {1'b0, dvs_q});
      end else begin
        rem_d = kfsl_pkg::WIDE_W'(shifted);
      end
      dvd_d  = {dvd_q[kfsl_pkg::TIME_W-2:0], 1'b0};
      quot_d = {quot_q[kfsl_pkg::FRAC_BITS-2:0], ge};
      cnt_d  = cnt_q - kfsl_pkg::STEP_W'(1);
      if (cnt_q == kfsl_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- src/keyframe_segment_lookup.sv -----
// Top level of the looping keyframe segment lookup with its sequencer and key table.
//
// Usage: items arrive on item_i (valid/ready). An append item stores key_time at the end of
// the table, a clear item empties it, and a query item looks up query_time in the looping
// animation. Every item gives exactly one result on result_o (valid/ready) carrying a status,
// the two bracketing keyframe indices and the Q1.16 blend fraction. The loop length is
// written on cfg_i, which is always ready; write it only while no item is in flight.
// Append, clear and trivial queries (table with fewer than two keys) finish in the accept
// cycle and show their result in the next cycle. A full query runs a modulo by the loop
// length when the time lies outside the loop (S_WRAP), a scan of the table (S_SCAN), a
// fetch and compare of the bracketing keys (S_FETCH1 to S_FETCH3, S_CALC, S_DECIDE), a
// fraction division unless the fraction is 0 or 1.0 (S_FRAC) and the load of the result
// register (S_DONE). The single restoring divider, one bit per cycle, and the one read
// port of the key table set its length. One item is worked on at a time.
// The result sits in an output register; while the receiver stalls, a query finishes its
// work and waits, and no new item is taken until the result register can be refilled.
// Reset empties the table, sets the loop length to 1.0 and drops any pending result.
module keyframe_segment_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  kfsl_cfg_if.sink    cfg_i,
  kfsl_in_if.sink     item_i,
  kfsl_out_if.source  result_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WRAP   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_FETCH1 = 4'd3;
  localparam logic [3:0] S_FETCH2 = 4'd4;
  localparam logic [3:0] S_FETCH3 = 4'd5;
  localparam logic [3:0] S_CALC   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_FRAC   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam int IW = kfsl_pkg::IDX_W;
  localparam int CW = kfsl_pkg::CNT_W;
  localparam int TW = kfsl_pkg::TIME_W;
  localparam int WW = kfsl_pkg::WIDE_W;

  // Key table, one write port for appends and one registered read port for the scan and the key fetch.
  logic [TW-1:0] mem [kfsl_pkg::MAX_KEYS];
  logic [TW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] rd_addr;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [TW-1:0] len_q;
  logic          out_valid_q, out_valid_d;

  logic [CW-1:0] n_q, n_d;
  logic          qneg_q, qneg_d;
  logic [TW-1:0] t_q, t_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pend_idx_q, pend_idx_d;
  logic [IW-1:0] k1_q, k1_d;
  logic [IW-1:0] k2_q, k2_d;
  logic [TW-1:0] t1_q, t1_d;
  logic [WW-1:0] t2_q, t2_d;
  logic [WW-1:0] num_q, num_d;
  logic [WW-1:0] den_q, den_d;
  logic          neg_q, neg_d;
  logic          eq_q, eq_d;
  logic [kfsl_pkg::FRAC_W-1:0] frac_q, frac_d;

  logic [kfsl_pkg::STAT_W-1:0] out_status_q;
  logic [IW-1:0]               out_k1_q, out_k2_q;
  logic [kfsl_pkg::FRAC_W-1:0] out_frac_q;

  logic                        out_load;
  logic [kfsl_pkg::STAT_W-1:0] ld_status;
  logic [IW-1:0]               ld_k1, ld_k2;
  logic [kfsl_pkg::FRAC_W-1:0] ld_frac;

  logic          slot_free, in_fire, out_fire;
  logic [TW-1:0] len_eff;
  logic [TW-1:0] mag;
  logic [TW-1:0] wrap_rem;
  logic          k1_last;
  logic [WW-1:0] t_adj, t1_wide;

  kfsl_pkg::div_req_t div_req;
  kfsl_pkg::div_rsp_t div_rsp;

  kfsl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // A zero loop length behaves as one LSB.
  assign len_eff   = (len_q == '0) ? TW'(1) : len_q;
  assign mag       = TW'(~item_i.query_time + TW'(1));
  assign wrap_rem  = div_rsp.rem[TW-1:0];
  assign k1_last   = (k1_q == IW'(n_q - CW'(1)));
  assign t1_wide   = {1'b0, t1_q};
  // A time below the first bracketing key lies in the next pass of the loop.
  assign t_adj     = (t_q < t1_q) ? ({1'b0, t_q} + {1'b0, len_eff}) : {1'b0, t_q};

  assign slot_free = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == S_IDLE) && slot_free;
  assign in_fire   = item_i.valid && item_i.ready;
  assign out_fire  = result_o.valid && result_o.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    n_d        = n_q;
    qneg_d     = qneg_q;
    t_d        = t_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    k1_d       = k1_q;
    k2_d       = k2_q;
    t1_d       = t1_q;
    t2_d       = t2_q;
    num_d      = num_q;
    den_d      = den_q;
    neg_d      = neg_q;
    eq_d       = eq_q;
    frac_d     = frac_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    rd_addr    = '0;
    div_req    = '0;
    out_load   = 1'b0;
    ld_status  = kfsl_pkg::ST_OK;
    ld_k1      = '0;
    ld_k2      = '0;
    ld_frac    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (item_i.operation)
            kfsl_pkg::OP_APPEND: begin
              out_load = 1'b1;
              if (count_q >= CW'(kfsl_pkg::MAX_KEYS)) begin
                ld_status = kfsl_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            kfsl_pkg::OP_CLEAR: begin
              out_load = 1'b1;
              count_d  = '0;
            end
            kfsl_pkg::OP_QUERY: begin
              n_d    = count_q;
              qneg_d = item_i.query_time[TW-1];
              k1_d   = IW'(count_q - CW'(1));
              if (count_q == '0) begin
                out_load  = 1'b1;
                ld_status = kfsl_pkg::ST_EMPTY;
              end else if (count_q == CW'(1)) begin
                out_load = 1'b1;
              end else if (item_i.query_time[TW-1] ||
                           (TW'(item_i.query_time) > len_eff)) begin
                // Time outside the loop: take the remainder by the loop length.
                div_req.start    = 1'b1;
                div_req.steps    = kfsl_pkg::STEP_W'(TW);
                div_req.init_rem = '0;
                div_req.dividend = item_i.query_time[TW-1] ? mag : TW'(item_i.query_time);
                div_req.divisor  = {1'b0, len_eff};
                state_d          = S_WRAP;
              end else begin
                t_d      = TW'(item_i.query_time);
                rd_idx_d = '0;
                pend_d   = 1'b0;
                state_d  = S_SCAN;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      S_WRAP: begin
        if (div_rsp.done) begin
          if (qneg_q) begin
            t_d = (wrap_rem == '0) ? '0 : (len_eff - wrap_rem);
          end else begin
            t_d = wrap_rem;
          end
          rd_idx_d = '0;
          pend_d   = 1'b0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        // Reads are issued one key a cycle; each key is compared the cycle after its read.
        if (rd_idx_q != n_q) begin
          mem_re     = 1'b1;
          rd_addr    = rd_idx_q[IW-1:0];
          rd_idx_d   = rd_idx_q + CW'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (rdata_q <= t_q)) begin
          k1_d = pend_idx_q;
        end
        if ((rd_idx_q == n_q) && !pend_q) begin
          state_d = S_FETCH1;
        end
      end

      S_FETCH1: begin
        mem_re  = 1'b1;
        rd_addr = k1_q;
        state_d = S_FETCH2;
      end

      S_FETCH2: begin
        t1_d    = rdata_q;
        mem_re  = 1'b1;
        rd_addr = k1_last ? '0 : (k1_q + IW'(1));
        k2_d    = rd_addr;
        state_d = S_FETCH3;
      end

      S_FETCH3: begin
        // Past the last key the segment wraps to the first key one loop later.
        if (k1_last) begin
          t2_d = {1'b0, len_eff} + {1'b0, rdata_q};
        end else begin
          t2_d = {1'b0, rdata_q};
        end
        state_d = S_CALC;
      end

      S_CALC: begin
        eq_d = (t2_q == t1_wide);
        if (t_adj >= t1_wide) begin
          num_d = t_adj - t1_wide;
          neg_d = 1'b0;
        end else begin
          num_d = t1_wide - t_adj;
          neg_d = 1'b1;
        end
        if (t2_q > t1_wide) begin
          den_d = t2_q - t1_wide;
        end else begin
          den_d = t1_wide - t2_q;
          neg_d = !neg_d;
        end
        state_d = S_DECIDE;
      end

      S_DECIDE: begin
        if (eq_q || neg_q || (num_q == '0)) begin
          frac_d  = '0;
          state_d = S_DONE;
        end else if (num_q >= den_q) begin
          frac_d  = kfsl_pkg::FRAC_ONE;
          state_d = S_DONE;
        end else begin
          // The numerator is below the denominator, so the quotient fits the fraction bits.
          div_req.start    = 1'b1;
          div_req.steps    = kfsl_pkg::STEP_W'(kfsl_pkg::FRAC_BITS);
          div_req.init_rem = num_q;
          div_req.dividend = '0;
          div_req.divisor  = den_q;
          state_d          = S_FRAC;
        end
      end

      S_FRAC: begin
        if (div_rsp.done) begin
          frac_d  = {1'b0, div_rsp.quot};
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_k1    = k1_q;
          ld_k2    = k2_q;
          ld_frac  = frac_q;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      len_q       <= TW'(1) << kfsl_pkg::FRAC_BITS;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (cfg_i.valid && cfg_i.ready) begin
        len_q <= cfg_i.animation_length;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    qneg_q     <= qneg_d;
    t_q        <= t_d;
    rd_idx_q   <= rd_idx_d;
    pend_idx_q <= pend_idx_d;
    k1_q       <= k1_d;
    k2_q       <= k2_d;
    t1_q       <= t1_d;
    t2_q       <= t2_d;
    num_q      <= num_d;
    den_q      <= den_d;
    neg_q      <= neg_d;
    eq_q       <= eq_d;
    frac_q     <= frac_d;
    if (out_load) begin
      out_status_q <= ld_status;
      out_k1_q     <= ld_k1;
      out_k2_q     <= ld_k2;
      out_frac_q   <= ld_frac;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IW-1:0]] <= item_i.key_time;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.status         = out_status_q;
  assign result_o.first_index    = out_k1_q;
  assign result_o.second_index   = out_k2_q;
  assign result_o.blend_fraction = out_frac_q;

endmodule
